// ----- rtl/tlb_lookup_fifo_lru_top_macros.svh -----
// ----------------------------------------------------------------------------
// TLB lookup assertion macros
// Shared concurrent assertion forms for the TLB checker.
// ----------------------------------------------------------------------------
`ifndef TLB_LOOKUP_FIFO_LRU_TOP_MACROS_SVH
`define TLB_LOOKUP_FIFO_LRU_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define TLBL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define TLBL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/tlbl_pkg.sv -----
// ----------------------------------------------------------------------------
// TLB lookup package
// Sizes, codes and the records passed along the cell chain.
// ----------------------------------------------------------------------------
package tlbl_pkg;

  localparam int ENTRIES   = 16;
  localparam int PAGE_BITS = 20;
  localparam int PID_W     = 16;
  localparam int FRAME_W   = 16;
  localparam int STAMP_W   = 32;
  localparam int COUNT_W   = 32;
  localparam int EIU_W     = 5;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 5;
  localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W     = $clog2(ENTRIES + 1);

  localparam logic FUNC_LOOKUP = 1'b0;
  localparam logic FUNC_FILL   = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_POLICY  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_COMMIT
  } tlbl_state_t;

  // Request and partial search result, handed from cell to cell.
  typedef struct packed {
    logic                 go;
    logic                 func;
    logic [PID_W-1:0]     pid;
    logic [PAGE_BITS-1:0] page;
    logic [FRAME_W-1:0]   frame;
    logic [CNT_W-1:0]     remaining;
    logic [IDX_W-1:0]     pos;
    logic                 hit;
    logic [IDX_W-1:0]     hit_idx;
    logic [FRAME_W-1:0]   hit_frame;
    logic                 empty_found;
    logic [IDX_W-1:0]     empty_idx;
    logic                 best_set;
    logic [IDX_W-1:0]     best_idx;
    logic [STAMP_W-1:0]   best_stamp;
    logic [PID_W-1:0]     best_pid;
    logic [PAGE_BITS-1:0] best_page;
  } tlbl_carry_t;

  // Update broadcast to the cells at commit.
  typedef struct packed {
    logic                 fill;
    logic [PID_W-1:0]     pid;
    logic [PAGE_BITS-1:0] page;
    logic [FRAME_W-1:0]   frame;
    logic [STAMP_W-1:0]   stamp;
  } tlbl_wr_t;

endpackage

// ----- rtl/tlbl_cell.sv -----
// ----------------------------------------------------------------------------
// TLB cell
// One entry: compares the passing request and forwards the search record.
// ----------------------------------------------------------------------------
module tlbl_cell
  import tlbl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  tlbl_carry_t carry_in,
  output tlbl_carry_t carry_out,
  input  logic        wr_en,
  input  tlbl_wr_t    wr
);

  logic                 valid;
  logic [PID_W-1:0]     pid;
  logic [PAGE_BITS-1:0] page;
  logic [FRAME_W-1:0]   frame;
  logic [STAMP_W-1:0]   stamp;
  tlbl_carry_t          carry_next;

  always_comb begin
    carry_next = carry_in;
    if (carry_in.remaining != '0) begin
      carry_next.remaining = carry_in.remaining - CNT_W'(1);
      // keep the lowest matching entry
      if (!carry_in.hit && valid && pid == carry_in.pid && page == carry_in.page) begin
        carry_next.hit       = 1'b1;
        carry_next.hit_idx   = carry_in.pos;
        carry_next.hit_frame = frame;
      end
      if (!carry_in.empty_found && !valid) begin
        carry_next.empty_found = 1'b1;
        carry_next.empty_idx   = carry_in.pos;
      end
      // strict compare: ties keep the lower entry
      if (!carry_in.best_set || stamp < carry_in.best_stamp) begin
        carry_next.best_set   = 1'b1;
        carry_next.best_idx   = carry_in.pos;
        carry_next.best_stamp = stamp;
        carry_next.best_pid   = pid;
        carry_next.best_page  = page;
      end
    end
    carry_next.pos = carry_in.pos + IDX_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      carry_out <= '0;
    end else begin
      carry_out <= carry_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (wr_en && wr.fill) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      stamp <= wr.stamp;
      if (wr.fill) begin
        pid   <= wr.pid;
        page  <= wr.page;
        frame <= wr.frame;
      end
    end
  end

endmodule

// ----- rtl/tlb_lookup_fifo_lru_top.sv -----
// ----------------------------------------------------------------------------
// TLB lookup with FIFO / LRU replacement
// Fully associative TLB keyed by pid and page, built as a chain of entry cells.
// ----------------------------------------------------------------------------
//
//   channel  | signals                                   | direction
//   ---------+-------------------------------------------+-----------
//   request  | in_valid, in_stall, func, pid, page, frame | in
//   result   | out_valid, out_stall, hit .. miss_total    | out
//   config   | cfg_we, cfg_index, cfg_data                | in
//
// A request is loaded into the first cell on the accept edge; the record walks
// the rest of the chain one cell per cycle, then the tail record is captured
// and the commit applies the update and loads the result.
// One request is in flight at a time; in_stall is high from accept to commit,
// so a new request is taken only after the previous one has committed.
// Reset clears all entry valid bits, the stamp, hit and miss counters, and
// returns the registers to 16 entries and FIFO policy.
// The result register holds while out_stall is high; a new request is still
// accepted, and its commit waits until the result slot frees.
//
module tlb_lookup_fifo_lru_top
  import tlbl_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // request channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 func,
  input  logic [PID_W-1:0]     pid,
  input  logic [PAGE_BITS-1:0] page,
  input  logic [FRAME_W-1:0]   frame,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 hit,
  output logic [FRAME_W-1:0]   hit_frame,
  output logic                 evicted_valid,
  output logic [PID_W-1:0]     evicted_pid,
  output logic [PAGE_BITS-1:0] evicted_page,
  output logic [COUNT_W-1:0]   hit_total,
  output logic [COUNT_W-1:0]   miss_total,
  // configuration
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  tlbl_state_t          state, state_next;
  logic [EIU_W-1:0]     entries_in_use;
  logic                 policy_lru;
  logic [CNT_W-1:0]     active_n;
  logic                 accept;
  logic                 capture;
  logic                 commit;
  logic                 enabled;
  tlbl_carry_t          chain [ENTRIES+1];
  tlbl_carry_t          pend;

  logic [STAMP_W-1:0]   stamp_counter, stamp_counter_next;
  logic [COUNT_W-1:0]   hit_counter, hit_counter_next;
  logic [COUNT_W-1:0]   miss_counter, miss_counter_next;

  logic                 do_write;
  logic [IDX_W-1:0]     wr_idx;
  tlbl_wr_t             wr;
  logic [ENTRIES-1:0]   wr_en;

  logic                 res_hit;
  logic [FRAME_W-1:0]   res_hit_frame;
  logic                 res_ev_valid;
  logic [PID_W-1:0]     res_ev_pid;
  logic [PAGE_BITS-1:0] res_ev_page;

  // Configuration registers; the user must make writes arrive only while idle, the block has no check of this.
  always_ff @(posedge clk) begin
    if (rst) begin
      entries_in_use <= EIU_W'(16);
      policy_lru     <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ENTRIES: entries_in_use <= cfg_data[EIU_W-1:0];
        CFG_POLICY:  policy_lru     <= cfg_data[0];
      endcase
    end
  end

  // Clamp an oversized count to the number of cells.
  always_comb begin
    if (32'(entries_in_use) > 32'(ENTRIES)) begin
      active_n = CNT_W'(ENTRIES);
    end else begin
      active_n = CNT_W'(entries_in_use);
    end
  end

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  // Launch record into the head of the chain.
  always_comb begin
    chain[0]           = '0;
    chain[0].go        = accept;
    chain[0].func      = func;
    chain[0].pid       = pid;
    chain[0].page      = page;
    chain[0].frame     = frame;
    chain[0].remaining = active_n;
  end

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    tlbl_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .carry_in  (chain[i]),
      .carry_out (chain[i+1]),
      .wr_en     (wr_en[i]),
      .wr        (wr)
    );
  end

  // Sequencer: idle -> sweep through the chain -> commit.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    capture    = 1'b0;
    commit     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_SWEEP;
      end
      ST_SWEEP: begin
        if (chain[ENTRIES].go) begin
          capture    = 1'b1;
          state_next = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        // wait for the result slot
        if (!out_valid || !out_stall) begin
          commit     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Hold the enable flag of the request and the finished search record.
  always_ff @(posedge clk) begin
    if (accept) enabled <= (active_n != '0);
    if (capture) pend <= chain[ENTRIES];
  end

  // Commit: decide counters, stamp and the entry update.
  always_comb begin
    stamp_counter_next = stamp_counter;
    hit_counter_next   = hit_counter;
    miss_counter_next  = miss_counter;
    do_write           = 1'b0;
    wr_idx             = pend.empty_found ? pend.empty_idx : pend.best_idx;
    wr.fill            = 1'b0;
    wr.pid             = pend.pid;
    wr.page            = pend.page;
    wr.frame           = pend.frame;
    wr.stamp           = stamp_counter + STAMP_W'(1);
    res_hit            = 1'b0;
    res_hit_frame      = '0;
    res_ev_valid       = 1'b0;
    res_ev_pid         = '0;
    res_ev_page        = '0;
    if (pend.func == FUNC_LOOKUP) begin
      res_hit       = pend.hit;
      res_hit_frame = pend.hit ? pend.hit_frame : '0;
      if (enabled) begin
        if (pend.hit) begin
          hit_counter_next = hit_counter + COUNT_W'(1);
          // LRU: refresh the stamp of the hit entry
          if (policy_lru) begin
            stamp_counter_next = wr.stamp;
            do_write           = 1'b1;
            wr_idx             = pend.hit_idx;
          end
        end else begin
          miss_counter_next = miss_counter + COUNT_W'(1);
        end
      end
    end else if (enabled) begin
      // fill the first empty entry, else the oldest stamp
      stamp_counter_next = wr.stamp;
      do_write           = 1'b1;
      wr.fill            = 1'b1;
      res_ev_valid       = !pend.empty_found;
      if (!pend.empty_found) begin
        res_ev_pid  = pend.best_pid;
        res_ev_page = pend.best_page;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      wr_en[i] = commit && do_write && (wr_idx == IDX_W'(i));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stamp_counter <= '0;
      hit_counter   <= '0;
      miss_counter  <= '0;
    end else if (commit) begin
      stamp_counter <= stamp_counter_next;
      hit_counter   <= hit_counter_next;
      miss_counter  <= miss_counter_next;
    end
  end

  // Result register: load on commit, drop when taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      hit           <= res_hit;
      hit_frame     <= res_hit_frame;
      evicted_valid <= res_ev_valid;
      evicted_pid   <= res_ev_pid;
      evicted_page  <= res_ev_page;
      hit_total     <= hit_counter_next;
      miss_total    <= miss_counter_next;
    end
  end

endmodule

// ----- rtl/tlbl_checker.sv -----
// ----------------------------------------------------------------------------
// TLB port checker
// Port-level checks on the TLB handshake and result encoding.
// ----------------------------------------------------------------------------
`include "tlb_lookup_fifo_lru_top_macros.svh"

module tlbl_checker
  import tlbl_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic                 hit,
  input logic [FRAME_W-1:0]   hit_frame,
  input logic                 evicted_valid,
  input logic [PID_W-1:0]     evicted_pid,
  input logic [PAGE_BITS-1:0] evicted_page
);

  `TLBL_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")
  `TLBL_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "second request taken while busy")
  `TLBL_ASSERT_NOW(a_hit_no_evict, out_valid, !(hit && evicted_valid), "hit and eviction in one result")
  `TLBL_ASSERT_NOW(a_miss_frame_zero, out_valid && !hit, hit_frame == '0, "frame set without hit")
  `TLBL_ASSERT_NOW(a_evict_zero, out_valid && !evicted_valid, evicted_pid == '0 && evicted_page == '0, "eviction fields set without eviction")

endmodule

bind tlb_lookup_fifo_lru_top tlbl_checker u_tlbl_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .hit           (hit),
  .hit_frame     (hit_frame),
  .evicted_valid (evicted_valid),
  .evicted_pid   (evicted_pid),
  .evicted_page  (evicted_page)
);
